### hdl/mrsl_pkg.sv
// ----------------------------------------------------------------------------
// mrsl_pkg
// Shared types and constants for the memory record stream loader.
// ----------------------------------------------------------------------------
package mrsl_pkg;

  localparam int BURST_LEN_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [7:0] CTRL_IRQ_ENABLE = 8'h01;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_IRQ   = 1'b1
  } kind_t;

  // Commands passed from the parser to the executor.
  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_BANK = 3'd1,
    OP_ADDR = 3'd2,
    OP_DATA = 3'd3,
    OP_IRQ  = 3'd4
  } op_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] bank;
    logic [7:0] address;
    logic [7:0] data_value;
    logic       burst_start;
    logic [4:0] burst_length;
  } out_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic [7:0] left;   // bytes left in the record, counting this one
    logic       clr;    // burst counter returns to zero after this command
  } cmd_t;

endpackage

### hdl/mrsl_front.sv
// ----------------------------------------------------------------------------
// mrsl_front
// Record parser: tracks the header phase and the byte count of the record and
// turns each input item into one command for the executor.
// ----------------------------------------------------------------------------
module mrsl_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mrsl_pkg::in_t in_data,
  input  logic          queue_full,
  output logic          push,
  output mrsl_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    PH_BANK = 3'd0,
    PH_ADDR = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CTRL = 3'd4
  } phase_t;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    phase_next      = phase;
    bytes_left_next = bytes_left;
    cmd.op          = mrsl_pkg::OP_NOP;
    cmd.value       = in_data.data_byte;
    cmd.left        = bytes_left;
    cmd.clr         = in_data.last_byte;
    case (phase)
      PH_ADDR: begin
        cmd.op     = mrsl_pkg::OP_ADDR;
        phase_next = PH_LEN;
      end
      PH_LEN: begin
        bytes_left_next = in_data.data_byte;
        cmd.clr         = 1'b1;
        phase_next      = (in_data.data_byte == 8'd0) ? PH_CTRL : PH_DATA;
      end
      PH_CTRL: begin
        if (in_data.data_byte == mrsl_pkg::CTRL_IRQ_ENABLE) begin
          cmd.op = mrsl_pkg::OP_IRQ;
        end
        phase_next = PH_BANK;
      end
      PH_DATA: begin
        cmd.op = mrsl_pkg::OP_DATA;
        if (bytes_left != 8'd0) begin
          bytes_left_next = bytes_left - 8'd1;
        end
        if (bytes_left_next == 8'd0) begin
          cmd.clr    = 1'b1;
          phase_next = PH_BANK;
        end
      end
      default: begin
        cmd.op     = mrsl_pkg::OP_BANK;
        phase_next = PH_ADDR;
      end
    endcase
    if (in_data.last_byte) begin
      phase_next      = PH_BANK;
      bytes_left_next = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_BANK;
      bytes_left <= 8'd0;
    end else if (push) begin
      phase      <= phase_next;
      bytes_left <= bytes_left_next;
    end
  end

endmodule

### hdl/mrsl_fifo.sv
// ----------------------------------------------------------------------------
// mrsl_fifo
// Short command queue between the parser and the executor.
// ----------------------------------------------------------------------------
module mrsl_fifo #(
  parameter int DEPTH = mrsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mrsl_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mrsl_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  mrsl_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  cnt;

  assign full      = (cnt == FULL_CNT);
  assign not_empty = (cnt != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CW'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= FULL_CNT)
    else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("pop from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  a_reset_empty: assert property (@(posedge clk) rst |=> cnt == '0)
    else $error("queue not empty after reset");
`endif

endmodule

### hdl/mrsl_back.sv
// ----------------------------------------------------------------------------
// mrsl_back
// Executor: applies bank and address commands, numbers data bytes, cuts them
// into aligned bursts and holds each result in the output register.
// ----------------------------------------------------------------------------
module mrsl_back #(
  parameter int BURST_LEN = mrsl_pkg::BURST_LEN_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  mrsl_pkg::cmd_t cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output mrsl_pkg::out_t out_data
);

  localparam int ADDR_SPAN = 256;

  // Distance from each address to the next burst boundary.
  logic [7:0] dist_tab [ADDR_SPAN];

  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_dist
    localparam int DIST = BURST_LEN - (g % BURST_LEN);
    assign dist_tab[g] = 8'(DIST);
  end

  logic [7:0]     bank;
  logic [7:0]     addr;
  logic [4:0]     burst_left;
  logic [7:0]     bank_next;
  logic [7:0]     addr_next;
  logic [4:0]     burst_left_next;
  logic [7:0]     blen;
  logic [7:0]     addr_inc;
  logic           has_result;
  mrsl_pkg::out_t result;

  assign pop = cmd_valid && (!out_valid || out_ready);

  always_comb begin
    bank_next       = bank;
    addr_next       = addr;
    burst_left_next = burst_left;
    has_result      = 1'b0;
    result          = '0;
    addr_inc        = addr + 8'd1;
    blen            = (cmd.left < dist_tab[addr]) ? cmd.left : dist_tab[addr];
    case (cmd.op)
      mrsl_pkg::OP_BANK: begin
        bank_next = cmd.value;
      end
      mrsl_pkg::OP_ADDR: begin
        addr_next = cmd.value;
      end
      mrsl_pkg::OP_IRQ: begin
        has_result  = 1'b1;
        result.kind = mrsl_pkg::KIND_IRQ;
      end
      mrsl_pkg::OP_DATA: begin
        has_result        = 1'b1;
        result.kind       = mrsl_pkg::KIND_WRITE;
        result.bank       = bank;
        result.address    = addr;
        result.data_value = cmd.value;
        if (burst_left == 5'd0) begin
          result.burst_start  = 1'b1;
          result.burst_length = blen[4:0];
          burst_left_next     = blen[4:0];
        end
        if (burst_left_next != 5'd0) begin
          burst_left_next = burst_left_next - 5'd1;
        end
        addr_next = addr_inc;
        if (addr_inc == 8'd0) begin
          bank_next = bank + 8'd1;
        end
      end
      default: begin
      end
    endcase
    if (cmd.clr) begin
      burst_left_next = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank       <= 8'd0;
      addr       <= 8'd0;
      burst_left <= 5'd0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        bank       <= bank_next;
        addr       <= addr_next;
        burst_left <= burst_left_next;
        out_valid  <= has_result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (pop && has_result) begin
      out_data <= result;
    end
  end

endmodule

### hdl/memory_record_stream_loader_core.sv
// Path: each accepted input item is written into the command queue, and its result
// is held in the executor's output register after the commands queued ahead of it.
// Throughput: one item per cycle; a result held by out_ready stalls the executor,
// and the four-entry command queue keeps in_ready high until it fills.
// Reset: rst is synchronous; it returns the parser to the bank byte, empties
// the queue and clears bank, address, burst count and the output valid.
// ----------------------------------------------------------------------------
// memory_record_stream_loader_core
// Loads bank/address/length records from a byte stream and emits one memory
// write per data byte, with aligned burst marks, plus interrupt requests.
// ----------------------------------------------------------------------------
module memory_record_stream_loader_core #(
  parameter int BURST_LEN   = mrsl_pkg::BURST_LEN_DEF,
  parameter int QUEUE_DEPTH = mrsl_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrsl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mrsl_pkg::out_t out_data
);

  logic           push;
  logic           pop;
  logic           full;
  logic           not_empty;
  mrsl_pkg::cmd_t push_cmd;
  mrsl_pkg::cmd_t head;

  mrsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  mrsl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  mrsl_back #(
    .BURST_LEN (BURST_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (not_empty),
    .cmd       (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
